// File: hdl/lss_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Line substring search package
// Request codes, the control group that runs the match cells, and case folding.
// ----------------------------------------------------------------------------
package lss_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned LineW   = 16;
  localparam int unsigned CtrW    = LineW + 1;
  localparam int unsigned ReqW    = 2;

  typedef enum logic [ReqW-1:0] {
    REQ_BEGIN   = 2'd0,
    REQ_PATTERN = 2'd1,
    REQ_TEXT    = 2'd2,
    REQ_EOL     = 2'd3
  } req_e;

  // Control broadcast from the sequencer to every cell of the chain.
  typedef struct packed {
    logic pat_wr;   // append the character to the pattern
    logic txt_en;   // advance the match chain with a text character
    logic clr;      // clear all match bits
  } cell_ctl_t;

  function automatic logic [CharW-1:0] fold_case(input logic [CharW-1:0] c);
    logic [CharW-1:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hdl/lss_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Line substring search match cell
// Holds one pattern character and one match bit; passes the bit to its
// right-hand neighbor on every text character.
// ----------------------------------------------------------------------------
module lss_cell #(
  parameter int unsigned PATTERN_MAX = 64,
  parameter int unsigned IDX         = 0
) (
  input  wire                                      clk_i,
  input  wire                                      rst_ni,
  input  lss_pkg::cell_ctl_t                       ctl_i,
  input  wire [lss_pkg::CharW-1:0]                 char_i,
  input  wire [$clog2(PATTERN_MAX+1)-1:0]          len_i,
  input  wire                                      match_prev_i,
  output logic                                     match_o,
  output logic                                     hit_o
);
  import lss_pkg::*;

  localparam int unsigned LenW = $clog2(PATTERN_MAX + 1);

  logic [CharW-1:0] pat_q;
  logic             match_q, match_d;
  logic             active;
  logic             is_last;

  assign active  = len_i > LenW'(IDX);
  assign is_last = len_i == LenW'(IDX + 1);

  always_comb begin
    match_d = match_q;
    if (ctl_i.clr) begin
      match_d = 1'b0;
    end else if (ctl_i.txt_en && active) begin
      match_d = match_prev_i && (pat_q == char_i);
    end
  end

  // The last cell of the pattern flags a complete match in this cycle.
  assign hit_o   = ctl_i.txt_en && is_last && match_d;
  assign match_o = match_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.pat_wr && len_i == LenW'(IDX)) begin
      pat_q <= char_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

endmodule
`default_nettype wire

// File: hdl/line_substring_search_core.sv
`default_nettype none
// A result is registered and appears on the master side in the cycle after its
// end-of-line transaction is accepted. Throughput: one transaction per cycle of
// any kind; the slave side stalls only while a finished result waits to be
// taken. Reset clears the counter, direction, pattern length, match bits and
// the result valid flag.
// ----------------------------------------------------------------------------
// Line substring search core
// Case-insensitive shift-and search over a chain of match cells, one per
// pattern character, with a line counter and a registered result stage.
// ----------------------------------------------------------------------------
module line_substring_search_core #(
  parameter int unsigned PATTERN_MAX = 64
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // Configuration: total_lines
  input  wire         cfg_we_i,
  input  wire  [15:0] cfg_wdata_i,
  // Slave side
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [31:0] s_axis_tdata,   // char_code[7:0], start_line[23:8], backward[24]
  input  wire  [1:0]  s_axis_tuser,   // req_type[1:0]
  // Master side
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [23:0] m_axis_tdata    // line_number[15:0], line_hit[16], in_range[17]
);
  import lss_pkg::*;

  localparam int unsigned LenW = $clog2(PATTERN_MAX + 1);

  logic             in_acc;
  req_e             req;
  logic [CharW-1:0] char_fold;
  cell_ctl_t        ctl;

  logic [PATTERN_MAX-1:0] match_vec;
  logic [PATTERN_MAX-1:0] hit_vec;

  logic [LenW-1:0]  len_q, len_d;
  logic [CtrW-1:0]  ctr_q, ctr_d;
  logic             down_q, down_d;
  logic             hit_q, hit_d;
  logic [LineW-1:0] total_q;
  logic             load_out;

  logic             out_valid_q;
  logic [23:0]      out_data_q;
  logic             line_hit, in_range;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign req           = req_e'(s_axis_tuser);
  assign char_fold     = fold_case(s_axis_tdata[7:0]);

  for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_cell
    logic prev;
    if (g == 0) begin : g_head
      assign prev = 1'b1;
    end else begin : g_body
      assign prev = match_vec[g-1];
    end
    lss_cell #(
      .PATTERN_MAX(PATTERN_MAX),
      .IDX        (g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .char_i      (char_fold),
      .len_i       (len_q),
      .match_prev_i(prev),
      .match_o     (match_vec[g]),
      .hit_o       (hit_vec[g])
    );
  end

  always_comb begin
    ctl      = '0;
    len_d    = len_q;
    ctr_d    = ctr_q;
    down_d   = down_q;
    hit_d    = hit_q;
    load_out = 1'b0;
    if (in_acc) begin
      unique case (req)
        REQ_BEGIN: begin
          ctl.clr = 1'b1;
          len_d   = '0;
          hit_d   = 1'b0;
          ctr_d   = {1'b0, s_axis_tdata[23:8]};
          down_d  = s_axis_tdata[24];
        end
        REQ_PATTERN: begin
          ctl.clr = 1'b1;
          hit_d   = 1'b0;
          // Characters past the last cell are dropped.
          if (len_q < LenW'(PATTERN_MAX)) begin
            ctl.pat_wr = 1'b1;
            len_d      = LenW'(len_q + 1'b1);
          end
        end
        REQ_TEXT: begin
          ctl.txt_en = 1'b1;
          if (|hit_vec) begin
            hit_d = 1'b1;
          end
        end
        REQ_EOL: begin
          ctl.clr  = 1'b1;
          hit_d    = 1'b0;
          load_out = 1'b1;
          ctr_d    = down_q ? CtrW'(ctr_q - 1'b1) : CtrW'(ctr_q + 1'b1);
        end
      endcase
    end
  end

  // An empty pattern matches every line.
  assign line_hit = (len_q == '0) || hit_q;
  assign in_range = !ctr_q[CtrW-1] && (ctr_q[LineW-1:0] < total_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      ctr_q       <= '0;
      down_q      <= 1'b0;
      hit_q       <= 1'b0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      len_q  <= len_d;
      ctr_q  <= ctr_d;
      down_q <= down_d;
      hit_q  <= hit_d;
      if (cfg_we_i) begin
        total_q <= cfg_wdata_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q <= {6'b0, in_range, line_hit, ctr_q[LineW-1:0]};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_len_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenW'(PATTERN_MAX))
    else $error("pattern length beyond cell count");

  a_eol_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && req == REQ_EOL) |=> (out_valid_q && out_data_q[15:0] == $past(ctr_q[15:0])))
    else $error("end-of-line transaction gave no matching result");

  a_clear_chain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (req == REQ_BEGIN || req == REQ_PATTERN)) |=> (match_vec == '0 && !hit_q))
    else $error("match chain not cleared");

  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!(in_acc && req == REQ_EOL) && !out_valid_q) |=> !out_valid_q)
    else $error("result without end-of-line transaction");

endmodule
`default_nettype wire
